### src/prewitt_edge_magnitude_macros.svh
// ----------------------------------------------------------------------------
// Prewitt edge magnitude assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PREWITT_EDGE_MAGNITUDE_MACROS_SVH
`define PREWITT_EDGE_MAGNITUDE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PEM_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PEM_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

### src/pem_pkg.sv
// ----------------------------------------------------------------------------
// Prewitt edge magnitude package
// Widths, register codes, shared types and the square root digit step.
// ----------------------------------------------------------------------------
package pem_pkg;

  localparam int unsigned MaxWidthDefault = 2048;
  localparam int unsigned MaxHeight       = 4096;
  localparam int unsigned MinDim          = 3;
  localparam int unsigned WidthReset      = 2048;
  localparam int unsigned HeightReset     = 2048;

  localparam int unsigned PixW       = 8;
  localparam int unsigned CfgWidthW  = 12;
  localparam int unsigned CfgHeightW = 13;
  localparam int unsigned RowW       = 12;
  localparam int unsigned GradW      = 11;
  localparam int unsigned EnergyW    = 21;
  localparam int unsigned RootW      = 8;
  localparam int unsigned RadicandW  = 2 * RootW;
  localparam int unsigned RemW       = RootW + 2;
  localparam int unsigned SqrtStages = 4;
  localparam int unsigned StepsPerStage = RootW / SqrtStages;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QFillW = $clog2(QDepth + 1);

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  typedef enum logic {
    RegWidth  = 1'b0,
    RegHeight = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [GradW-1:0] gh;
    logic signed [GradW-1:0] gv;
    logic                    last;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic              nonempty;
    logic [QFillW-1:0] fill;
    job_t              head;
  } q_stat_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_t;

  function automatic sqrt_t sqrt_step(sqrt_t s, logic [1:0] pair);
    logic [RemW+1:0] cur;
    logic [RemW+1:0] trial;
    sqrt_t           r;
    cur   = {s.rem, pair};
    trial = (RemW + 2)'({s.root, 2'b01});
    if (cur >= trial) begin
      r.rem  = RemW'(cur - trial);
      r.root = {s.root[RootW-2:0], 1'b1};
    end else begin
      r.rem  = cur[RemW-1:0];
      r.root = {s.root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### src/pem_pix_if.sv
// ----------------------------------------------------------------------------
// Pixel stream interface
// Valid/ready channel carrying one grey pixel and its frame start mark.
// ----------------------------------------------------------------------------
interface pem_pix_if import pem_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel;
  logic            frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink (input valid, pixel, frame_start, output ready);
endinterface

### src/pem_mag_if.sv
// ----------------------------------------------------------------------------
// Magnitude stream interface
// Valid/ready channel carrying one edge magnitude and its end of frame flag.
// ----------------------------------------------------------------------------
interface pem_mag_if import pem_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RootW-1:0] magnitude;
  logic             last_in_frame;

  modport source (output valid, magnitude, last_in_frame, input ready);
  modport sink (input valid, magnitude, last_in_frame, output ready);
endinterface

### src/pem_queue.sv
// ----------------------------------------------------------------------------
// Gradient job queue
// Short FIFO of gradient pairs between the window front and the root pipeline.
// ----------------------------------------------------------------------------
module pem_queue import pem_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output q_stat_t q_stat_o
);

  job_t              entry_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QFillW-1:0] fill_q, fill_d;

  always_comb begin
    wr_ptr_d = push_i.valid ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q + QFillW'(push_i.valid) - QFillW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      entry_q[wr_ptr_q] <= push_i.job;
    end
  end

  assign q_stat_o.nonempty = (fill_q != '0);
  assign q_stat_o.fill     = fill_q;
  assign q_stat_o.head     = entry_q[rd_ptr_q];

endmodule

### src/pem_front.sv
// ----------------------------------------------------------------------------
// Prewitt window front end
// Raster counters, line store, 3x3 window and gradient sums for the queue.
// ----------------------------------------------------------------------------
module pem_front import pem_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pem_pix_if.sink               pix_i,
  input  logic [CfgWidthW-1:0]  width_i,
  input  logic [CfgHeightW-1:0] height_i,
  input  q_stat_t               q_stat_i,
  output push_t                 push_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (CfgWidthW > $clog2(MAX_WIDTH + 1)) ?
                               CfgWidthW : $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = CfgHeightW;
  localparam int unsigned LW = 2 * PixW;

  logic [WW-1:0]   w_eff, w_last;
  logic [HW-1:0]   h_eff, h_last;
  logic            accept;
  logic [CW-1:0]   col_cur;
  logic [RowW-1:0] row_cur;
  logic            emit_cur, last_cur;

  logic [CW-1:0]   col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic [LW-1:0]   line_mem [MAX_WIDTH];
  logic [LW-1:0]   rd_q;
  logic [LW-1:0]   byp_q;
  logic            byp_hit_q;

  logic            v1_q, emit1_q, last1_q;
  logic [CW-1:0]   col1_q;
  logic [PixW-1:0] px1_q;
  logic [PixW-1:0] top, mid;

  logic [PixW-1:0] win_q [9];
  logic            v2_q, last2_q;

  logic [GradW-1:0] sum_top, sum_bot, sum_left, sum_right;
  logic [QFillW:0]  in_flight;

  always_comb begin
    if (WW'(width_i) < WW'(MinDim)) begin
      w_eff = WW'(MinDim);
    end else if (WW'(width_i) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_i);
    end
    if (height_i < HW'(MinDim)) begin
      h_eff = HW'(MinDim);
    end else if (height_i > HW'(MaxHeight)) begin
      h_eff = HW'(MaxHeight);
    end else begin
      h_eff = height_i;
    end
    w_last = w_eff - 1'b1;
    h_last = h_eff - 1'b1;
  end

  assign in_flight   = (QFillW + 1)'(q_stat_i.fill) + (QFillW + 1)'(v1_q)
                     + (QFillW + 1)'(v2_q);
  assign pix_i.ready = (in_flight < (QFillW + 1)'(QDepth));
  assign accept      = pix_i.valid & pix_i.ready;

  always_comb begin
    col_cur  = pix_i.frame_start ? '0 : col_q;
    row_cur  = pix_i.frame_start ? '0 : row_q;
    emit_cur = (WW'(col_cur) >= WW'(2)) && (WW'(col_cur) <= w_last) &&
               (HW'(row_cur) >= HW'(2)) && (HW'(row_cur) <= h_last);
    last_cur = (WW'(col_cur) == w_last) && (HW'(row_cur) == h_last);
    if (WW'(col_cur) >= w_last) begin
      col_d = '0;
      row_d = (HW'(row_cur) >= h_last) ? '0 : row_cur + 1'b1;
    end else begin
      col_d = col_cur + 1'b1;
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      v1_q      <= 1'b0;
      byp_hit_q <= 1'b0;
      v2_q      <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q & emit1_q;
      if (accept) begin
        col_q     <= col_d;
        row_q     <= row_d;
        byp_hit_q <= v1_q && (col1_q == col_cur);
      end
    end
  end

  assign top = byp_hit_q ? byp_q[LW-1:PixW] : rd_q[LW-1:PixW];
  assign mid = byp_hit_q ? byp_q[PixW-1:0]  : rd_q[PixW-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q    <= line_mem[col_cur];
      byp_q   <= {mid, px1_q};
      col1_q  <= col_cur;
      px1_q   <= pix_i.pixel;
      emit1_q <= emit_cur;
      last1_q <= last_cur;
    end
    if (v1_q) begin
      line_mem[col1_q] <= {mid, px1_q};
      last2_q          <= last1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (v1_q) begin
      for (int i = 0; i < 3; i++) begin
        win_q[3*i]   <= win_q[3*i+1];
        win_q[3*i+1] <= win_q[3*i+2];
      end
      win_q[2] <= top;
      win_q[5] <= mid;
      win_q[8] <= px1_q;
    end
  end

  always_comb begin
    sum_top   = GradW'(win_q[0]) + GradW'(win_q[1]) + GradW'(win_q[2]);
    sum_bot   = GradW'(win_q[6]) + GradW'(win_q[7]) + GradW'(win_q[8]);
    sum_left  = GradW'(win_q[0]) + GradW'(win_q[3]) + GradW'(win_q[6]);
    sum_right = GradW'(win_q[2]) + GradW'(win_q[5]) + GradW'(win_q[8]);
    push_o.valid    = v2_q;
    push_o.job.gh   = sum_top - sum_bot;
    push_o.job.gv   = sum_left - sum_right;
    push_o.job.last = last2_q;
  end

endmodule

### src/pem_back.sv
// ----------------------------------------------------------------------------
// Prewitt magnitude back end
// Gradient energy, pipelined integer square root and the output register.
// ----------------------------------------------------------------------------
module pem_back import pem_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_stat_t   q_stat_i,
  output logic      pop_o,
  pem_mag_if.source mag_o
);

  logic                        adv;
  logic signed [2*GradW-1:0]   prod_h, prod_v;
  logic        [EnergyW-1:0]   energy;

  logic                        v_q    [SqrtStages+1];
  sqrt_t                       st_q   [SqrtStages+1];
  logic        [RadicandW-1:0] n_q    [SqrtStages+1];
  logic                        sat_q  [SqrtStages+1];
  logic                        last_q [SqrtStages+1];

  assign adv   = !v_q[SqrtStages] | mag_o.ready;
  assign pop_o = adv & q_stat_i.nonempty;

  always_comb begin
    prod_h = q_stat_i.head.gh * q_stat_i.head.gh;
    prod_v = q_stat_i.head.gv * q_stat_i.head.gv;
    energy = EnergyW'(prod_h) + EnergyW'(prod_v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0]   <= '0;
      n_q[0]    <= energy[RadicandW-1:0];
      sat_q[0]  <= |energy[EnergyW-1:RadicandW];
      last_q[0] <= q_stat_i.head.last;
    end
  end

  for (genvar k = 1; k <= SqrtStages; k++) begin : g_root
    sqrt_t s;

    always_comb begin
      s = st_q[k-1];
      for (int j = 0; j < StepsPerStage; j++) begin
        s = sqrt_step(s, n_q[k-1][RadicandW-1-2*(StepsPerStage*(k-1)+j) -: 2]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[k]   <= s;
        n_q[k]    <= n_q[k-1];
        sat_q[k]  <= sat_q[k-1];
        last_q[k] <= last_q[k-1];
      end
    end
  end

  assign mag_o.valid         = v_q[SqrtStages];
  assign mag_o.magnitude     = sat_q[SqrtStages] ? '1 : st_q[SqrtStages].root;
  assign mag_o.last_in_frame = last_q[SqrtStages];

endmodule

### src/prewitt_edge_magnitude.sv
// ----------------------------------------------------------------------------
// Prewitt edge magnitude
// Streaming 3x3 Prewitt gradient magnitude over 8-bit grey raster images.
// ----------------------------------------------------------------------------
// Pixels enter on pix_i in raster order; frame_start marks row 0, column 0.
// Each pixel completes the window centred one row up and one column left;
// interior centres give one magnitude on mag_o, border centres give none, and
// the last interior result of a frame carries last_in_frame.
// Image width and height must be written over the APB port only while the
// block is idle; the block itself does not enforce this. pready is always
// high and every register reads back. While mag_o accepts results, a pixel
// is taken every cycle in steady state. A result passes through the line
// store read and window update, the gradient queue, the energy multiply and
// the two-digit-per-stage square root pipeline.
// When mag_o stalls, the root pipeline holds and the queue fills; pix_i.ready
// drops once the queue and the two window stages would overrun the queue.
// Reset clears the counters, the window and the pipeline; the line store is
// not cleared and the first rows of a frame fill it before any result uses it.
// ----------------------------------------------------------------------------
`include "prewitt_edge_magnitude_macros.svh"

module prewitt_edge_magnitude import pem_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pem_pix_if.sink             pix_i,
  pem_mag_if.source           mag_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [CfgWidthW-1:0]  width_q;
  logic [CfgHeightW-1:0] height_q;
  logic                  cfg_wr;
  reg_idx_e              reg_idx;

  push_t   push;
  q_stat_t q_stat;
  logic    pop;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[ApbAddrW-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgWidthW'(WidthReset);
      height_q <= CfgHeightW'(HeightReset);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegWidth:  width_q  <= pwdata[CfgWidthW-1:0];
        RegHeight: height_q <= pwdata[CfgHeightW-1:0];
        default:   width_q  <= width_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegWidth:  prdata = ApbDataW'(width_q);
      RegHeight: prdata = ApbDataW'(height_q);
      default:   prdata = '0;
    endcase
  end

  pem_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_i    (pix_i),
    .width_i  (width_q),
    .height_i (height_q),
    .q_stat_i (q_stat),
    .push_o   (push)
  );

  pem_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .q_stat_o (q_stat)
  );

  pem_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .mag_o    (mag_o)
  );

  `PEM_ASSERT_IMP(a_queue_no_overflow, clk_i, rst_ni, push.valid, q_stat.fill != QFillW'(QDepth), "gradient queue written while full")
  `PEM_ASSERT_IMP(a_queue_drains, clk_i, rst_ni, q_stat.nonempty && !mag_o.valid, pop, "queued job held while output stage empty")
  `PEM_ASSERT_NXT(a_push_lands, clk_i, rst_ni, push.valid && !pop, q_stat.nonempty, "pushed job missing from queue")

endmodule
